/* src/stp_pkg.sv */
// Shared constants for the SPI temperature sensor poller: SPI command bytes,
// CSR indexes and reset values, and the temperature conversion.
// No dependencies.
`timescale 1ns / 1ps

package stp_pkg;

   localparam int unsigned TICK_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TEMP_W = 12;
   localparam int unsigned STEP_W = 4;
   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 32;

   // SPI command bytes
   localparam logic [BYTE_W-1:0] CMD_MODE_WR  = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_MODE_CNT = 8'h04;
   localparam logic [BYTE_W-1:0] CMD_READ     = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_DUMMY    = 8'h00;
   localparam logic [BYTE_W-1:0] CTRL_OK      = 8'h04;

   // read sequence steps: even steps send, odd steps wait for a reply
   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MSB   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FRAC  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_CTRL  = 4'd11;

   // CSR indexes (byte address / 4)
   localparam logic [1:0] CSR_RESET_TICKS   = 2'd0;
   localparam logic [1:0] CSR_MEAS_TICKS    = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [TICK_W-1:0] RESET_TICKS_DEF   = 16'd20;
   localparam logic [TICK_W-1:0] MEAS_TICKS_DEF    = 16'd200;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_DEF = 16'd10;
   localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

   // tenths of a degree: msb*10 + (frac*25)/10
   function automatic logic [TEMP_W-1:0] temp_tenths(input logic [BYTE_W-1:0] msb,
                                                     input logic [1:0] frac);
      logic [TEMP_W-1:0] frac_part;
      case (frac)
         2'd0:    frac_part = 12'd0;
         2'd1:    frac_part = 12'd2;
         2'd2:    frac_part = 12'd5;
         default: frac_part = 12'd7;
      endcase
      return {1'b0, msb, 3'b000} + {3'b000, msb, 1'b0} + frac_part;
   endfunction

endpackage

/* src/spi_temp_sensor_poller.sv */
// SPI temperature sensor poller: tick-driven sequencer with APB-style CSRs.
// Depends on stp_pkg.
`timescale 1ns / 1ps

// One request word per scheduler tick; on acceptance of the word, its
// response appears in the output register on the next cycle. Each tick gives
// one response word, except the tick that sends the 0x80/0x04 mode command,
// which gives two (last marks the second). While a response waits, a new tick
// is still taken in the cycle the final word of the previous one leaves, so
// the sustained rate is one tick per cycle while rsp_ready is high; a command
// pair holds off new ticks while the single output register holds its first word.
module spi_temp_sensor_poller (
   input  logic        clock,
   input  logic        reset,
   // tick channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_enable,
   input  logic        req_alarm_ok,
   input  logic        req_request,
   input  logic        req_rx_valid,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_chip_enable,
   output logic        rsp_spi_reset,
   output logic        rsp_temp_valid,
   output logic [11:0] rsp_temperature,
   output logic        rsp_sensor_error,
   output logic        rsp_request_pending,
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ARMED,
      PH_WAIT_MEAS,
      PH_READ,
      PH_CALC,
      PH_FAIL
   } phase_type;

   // CSRs
   logic [stp_pkg::TICK_W-1:0] reset_ticks_ff, reset_ticks_in;
   logic [stp_pkg::TICK_W-1:0] meas_ticks_ff, meas_ticks_in;
   logic [stp_pkg::TICK_W-1:0] timeout_ticks_ff, timeout_ticks_in;

   // sequencer state
   phase_type                  phase_ff, phase_in;
   logic [stp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       rst_phase_ff, rst_phase_in;
   logic [stp_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [stp_pkg::BYTE_W-1:0] msb_ff, msb_in;
   logic [1:0]                 frac_ff, frac_in;
   logic                       ce_ff, ce_in;
   logic                       pend_ff, pend_in;
   logic [stp_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic                       err_ff, err_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic                       out_txv_ff, out_txv_in;
   logic [stp_pkg::BYTE_W-1:0] out_txb_ff, out_txb_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_ce_ff, out_ce_in;
   logic                       out_srst_ff, out_srst_in;
   logic                       out_tv_ff, out_tv_in;
   logic [stp_pkg::TEMP_W-1:0] out_temp_ff, out_temp_in;
   logic                       out_err_ff, out_err_in;
   logic                       out_pend_ff, out_pend_in;

   logic                       accept;
   logic                       csr_wr;
   logic [1:0]                 csr_idx;
   logic [stp_pkg::TICK_W-1:0] tick_inc;
   logic                       srst_pulse;
   logic                       tv_pulse;
   logic                       txv;
   logic [stp_pkg::BYTE_W-1:0] txb;
   logic                       pair;

   assign req_ready  = !out_valid_ff || (rsp_ready && out_last_ff);
   assign accept     = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];
   assign tick_inc   = (tick_ff == stp_pkg::TICK_MAX) ? tick_ff : tick_ff + 16'd1;

   always_comb begin
      case (csr_idx)
         stp_pkg::CSR_RESET_TICKS:   csr_prdata = {16'd0, reset_ticks_ff};
         stp_pkg::CSR_MEAS_TICKS:    csr_prdata = {16'd0, meas_ticks_ff};
         stp_pkg::CSR_TIMEOUT_TICKS: csr_prdata = {16'd0, timeout_ticks_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   always_comb begin
      reset_ticks_in   = reset_ticks_ff;
      meas_ticks_in    = meas_ticks_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_wr) begin
         case (csr_idx)
            stp_pkg::CSR_RESET_TICKS:   reset_ticks_in   = csr_pwdata[15:0];
            stp_pkg::CSR_MEAS_TICKS:    meas_ticks_in    = csr_pwdata[15:0];
            stp_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // one tick of the sequencer
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      rst_phase_in = rst_phase_ff;
      tick_in      = tick_ff;
      msb_in       = msb_ff;
      frac_in      = frac_ff;
      ce_in        = ce_ff;
      pend_in      = pend_ff;
      temp_in      = temp_ff;
      err_in       = err_ff;
      srst_pulse   = 1'b0;
      tv_pulse     = 1'b0;
      txv          = 1'b0;
      txb          = stp_pkg::CMD_DUMMY;
      pair         = 1'b0;

      if (accept) begin
         if (req_request) begin
            pend_in = 1'b1;
         end
         tick_in = tick_inc;
         case (phase_ff)
            PH_IDLE: begin
               if (req_enable) begin
                  if (rst_phase_ff) begin
                     srst_pulse   = 1'b1;
                     ce_in        = 1'b0;
                     tick_in      = '0;
                     rst_phase_in = 1'b0;
                  end else if (tick_inc >= reset_ticks_ff) begin
                     tick_in      = '0;
                     ce_in        = 1'b1;
                     rst_phase_in = 1'b1;
                     pair         = 1'b1;
                     phase_in     = PH_ARMED;
                  end
               end
            end
            PH_ARMED: begin
               if (req_alarm_ok) begin
                  if (!req_enable) begin
                     phase_in = PH_IDLE;
                  end else if (pend_ff || req_request) begin
                     tick_in  = '0;
                     ce_in    = 1'b0;
                     phase_in = PH_WAIT_MEAS;
                  end
               end
            end
            PH_WAIT_MEAS: begin
               if (tick_inc >= meas_ticks_ff) begin
                  ce_in    = 1'b1;
                  msb_in   = '0;
                  frac_in  = '0;
                  step_in  = stp_pkg::STEP_FIRST;
                  phase_in = PH_READ;
               end
            end
            PH_READ: begin
               if (step_ff <= stp_pkg::STEP_CTRL) begin
                  if (!step_ff[0]) begin
                     txv     = 1'b1;
                     txb     = (step_ff == stp_pkg::STEP_FIRST) ? stp_pkg::CMD_READ
                                                                 : stp_pkg::CMD_DUMMY;
                     tick_in = '0;
                     step_in = step_ff + 4'd1;
                  end else if (!req_rx_valid) begin
                     if (tick_inc >= timeout_ticks_ff) begin
                        err_in   = 1'b1;
                        phase_in = PH_FAIL;
                     end
                  end else begin
                     tick_in = '0;
                     if (step_ff == stp_pkg::STEP_MSB) begin
                        msb_in = req_rx_byte;
                     end
                     if (step_ff == stp_pkg::STEP_FRAC) begin
                        frac_in = req_rx_byte[7:6];
                     end
                     if (step_ff == stp_pkg::STEP_CTRL) begin
                        if (req_rx_byte != stp_pkg::CTRL_OK) begin
                           err_in   = 1'b1;
                           phase_in = PH_FAIL;
                        end else begin
                           err_in   = 1'b0;
                           phase_in = PH_CALC;
                        end
                     end else begin
                        step_in = step_ff + 4'd1;
                     end
                  end
               end
            end
            PH_CALC: begin
               temp_in  = stp_pkg::temp_tenths(msb_ff, frac_ff);
               tv_pulse = 1'b1;
               pend_in  = 1'b0;
               phase_in = PH_ARMED;
            end
            PH_FAIL: begin
               pend_in  = 1'b0;
               phase_in = PH_IDLE;
            end
            default: ;
         endcase
      end
   end

   // output register; a command pair leaves 0x80 first, then 0x04 with last
   always_comb begin
      out_valid_in = out_valid_ff;
      out_txv_in   = out_txv_ff;
      out_txb_in   = out_txb_ff;
      out_last_in  = out_last_ff;
      out_ce_in    = out_ce_ff;
      out_srst_in  = out_srst_ff;
      out_tv_in    = out_tv_ff;
      out_temp_in  = out_temp_ff;
      out_err_in   = out_err_ff;
      out_pend_in  = out_pend_ff;
      if (accept) begin
         out_valid_in = 1'b1;
         out_txv_in   = pair ? 1'b1 : txv;
         out_txb_in   = pair ? stp_pkg::CMD_MODE_WR : txb;
         out_last_in  = !pair;
         out_ce_in    = ce_in;
         out_srst_in  = srst_pulse;
         out_tv_in    = tv_pulse;
         out_temp_in  = temp_in;
         out_err_in   = err_in;
         out_pend_in  = pend_in;
      end else if (out_valid_ff && rsp_ready) begin
         if (out_last_ff) begin
            out_valid_in = 1'b0;
         end else begin
            out_txb_in  = stp_pkg::CMD_MODE_CNT;
            out_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_ticks_ff   <= stp_pkg::RESET_TICKS_DEF;
         meas_ticks_ff    <= stp_pkg::MEAS_TICKS_DEF;
         timeout_ticks_ff <= stp_pkg::TIMEOUT_TICKS_DEF;
         phase_ff         <= PH_IDLE;
         step_ff          <= '0;
         rst_phase_ff     <= 1'b1;
         tick_ff          <= '0;
         msb_ff           <= '0;
         frac_ff          <= '0;
         ce_ff            <= 1'b0;
         pend_ff          <= 1'b0;
         temp_ff          <= '0;
         err_ff           <= 1'b0;
         out_valid_ff     <= 1'b0;
         out_last_ff      <= 1'b1;
      end else begin
         reset_ticks_ff   <= reset_ticks_in;
         meas_ticks_ff    <= meas_ticks_in;
         timeout_ticks_ff <= timeout_ticks_in;
         phase_ff         <= phase_in;
         step_ff          <= step_in;
         rst_phase_ff     <= rst_phase_in;
         tick_ff          <= tick_in;
         msb_ff           <= msb_in;
         frac_ff          <= frac_in;
         ce_ff            <= ce_in;
         pend_ff          <= pend_in;
         temp_ff          <= temp_in;
         err_ff           <= err_in;
         out_valid_ff     <= out_valid_in;
         out_last_ff      <= out_last_in;
      end
      out_txv_ff  <= out_txv_in;
      out_txb_ff  <= out_txb_in;
      out_ce_ff   <= out_ce_in;
      out_srst_ff <= out_srst_in;
      out_tv_ff   <= out_tv_in;
      out_temp_ff <= out_temp_in;
      out_err_ff  <= out_err_in;
      out_pend_ff <= out_pend_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_tx_valid        = out_txv_ff;
   assign rsp_tx_byte         = out_txb_ff;
   assign rsp_last            = out_last_ff;
   assign rsp_chip_enable     = out_ce_ff;
   assign rsp_spi_reset       = out_srst_ff;
   assign rsp_temp_valid      = out_tv_ff;
   assign rsp_temperature     = out_temp_ff;
   assign rsp_sensor_error    = out_err_ff;
   assign rsp_request_pending = out_pend_ff;

   // first word of a pair blocks new ticks
   a_pair_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> !req_ready)
      else $error("tick taken while mode command pair incomplete");

   // taking the 0x80 word is followed by the closing 0x04 word
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ready && !out_last_ff) |=>
         (out_valid_ff && out_last_ff && out_txb_ff == stp_pkg::CMD_MODE_CNT))
      else $error("second word of mode command pair missing");

   // reads only happen with chip enable raised
   a_read_ce: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READ) |-> ce_ff)
      else $error("read sequence with chip enable low");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= stp_pkg::STEP_CTRL)
      else $error("read step out of range");

   // a published temperature never coincides with a transmitted byte
   a_tv_no_tx: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_tv_ff) |-> !out_txv_ff)
      else $error("temperature published with SPI byte");

endmodule
